>>> rtl/esest_pkg.sv
`default_nettype none

package esest_pkg;

    // Field and register widths.
    localparam int POS_W      = 32;
    localparam int SPEED_W    = 32;
    localparam int CPR_W      = 25;
    localparam int RATE_W     = 16;
    localparam int CFG_DATA_W = 25;
    localparam int CFG_IDX_W  = 1;

    // Default width of the period counter.
    localparam int PERIOD_COUNT_W_DEF = 16;

    // Datapath widths.
    localparam int DELTA_W = 33;               // wrapped difference, signed
    localparam int MAG_W   = 32;               // magnitude of the wrapped difference
    localparam int PROD_W  = MAG_W + RATE_W;   // |delta| * rate
    localparam int DIV_W   = 57;               // dividend magnitude of the shared divider
    localparam int NUM_W   = DIV_W + 1;        // signed numerator of the average
    localparam int S19_W   = 37;               // 19 * speed, signed

    // Q23.8 scaling and filter constants.
    localparam int Q_SHIFT     = 8;
    localparam int AVG_DIVISOR = 20;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_CPR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE = 1'b1;

    localparam logic [CPR_W-1:0]  CPR_RESET  = 25'd4096;
    localparam logic [RATE_W-1:0] RATE_RESET = 16'd1000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_WRAP,
        ST_SIGN,
        ST_MUL,
        ST_TERM,
        ST_SUM,
        ST_AVG,
        ST_QUOT,
        ST_LIMIT,
        ST_DONE
    } t_state;

    // What the finished item does to the stored state.
    typedef enum logic [1:0] {
        K_COUNT,
        K_FIRST,
        K_UPDATE,
        K_CLAMP
    } t_kind;

endpackage

`default_nettype wire

>>> rtl/esest_sermul.sv
`default_nettype none

// Shift-and-add multiplier, one multiplier bit per cycle.
module esest_sermul
    import esest_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [MAG_W-1:0]  i_mcand,
    input  wire logic [RATE_W-1:0] i_mplr,
    output logic                   o_done,
    output logic [PROD_W-1:0]      o_prod
);

    localparam int CNT_W = $clog2(RATE_W + 1);

    logic [PROD_W-1:0] r_prod;
    logic [MAG_W-1:0]  r_mcand;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [MAG_W:0]    step_sum;

    assign step_sum = {1'b0, r_prod[PROD_W-1:RATE_W]}
                    + (r_prod[0] ? {1'b0, r_mcand} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RATE_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod  <= {{MAG_W{1'b0}}, i_mplr};
            r_mcand <= i_mcand;
        end else if (r_busy) begin
            r_prod <= {step_sum, r_prod[RATE_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

>>> rtl/esest_serdiv.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, unsigned operands.
module esest_serdiv
    import esest_pkg::*;
#(
    parameter int DVW = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [DVW-1:0]   i_divisor,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_quo;
    logic [DVW-1:0]   r_rem;
    logic [DVW-1:0]   r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVW:0]     trial;
    logic [DVW:0]     diff;
    logic             fits;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_rem <= fits ? diff[DVW-1:0] : trial[DVW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> rtl/encoder_speed_estimator.sv
`default_nettype none

// Channel   Direction  Handshake                Payload
// -------   ---------  -----------------------  ------------------------------------
// sample    in         i_in_valid / o_in_ready  i_mode, i_encoder_position
// speed     out        o_out_valid/ i_out_ready o_speed_estimate (signed Q23.8)
// config    in         i_cfg_we (no wait)       i_cfg_index, i_cfg_data
//
// Every accepted item produces exactly one speed item. An error sample or the
// first valid reading goes from the difference state straight to the done
// state. A valid reading with a difference of at least 4 counts runs 16 steps
// of the serial multiplier and two 57-step passes through the shared serial
// divider (the update term, then the division by 20 of the average). A small
// difference takes one divider pass, for the clamp limit.
// Reset is synchronous and active low; it restores the register defaults
// (4096 counts per revolution, 1000 Hz) and clears speed, count and position.
// The block takes one item at a time. A finished result waits in the output
// register, and the next item is accepted and worked on meanwhile; it stalls
// only at its own end until the previous result has been taken.
module encoder_speed_estimator
    import esest_pkg::*;
#(
    parameter int PERIOD_COUNT_WIDTH = PERIOD_COUNT_W_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_mode,
    input  wire logic [POS_W-1:0]      i_encoder_position,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [SPEED_W-1:0]         o_speed_estimate,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PCW = PERIOD_COUNT_WIDTH;
    // The divisor is either the incremented period count or the constant 20.
    localparam int DVW = (PCW > 5) ? PCW : 5;

    // Configuration registers.
    logic [CPR_W-1:0]  r_cpr;
    logic [RATE_W-1:0] r_rate;

    // Architectural state.
    logic                      r_awaiting;
    logic [POS_W-1:0]          r_last;
    logic [PCW-1:0]            r_periods;
    logic signed [SPEED_W-1:0] r_speed;

    // Sequencer and per-item working registers.
    t_state                    r_state, n_state;
    t_kind                     r_kind;
    logic                      r_mode;
    logic [POS_W-1:0]          r_pos;
    logic [POS_W-1:0]          r_diff;
    logic signed [DELTA_W-1:0] r_delta;
    logic                      r_neg;
    logic signed [S19_W-1:0]   r_s19;
    logic signed [NUM_W-1:0]   r_num;
    logic [SPEED_W-1:0]        r_new_speed;
    logic                      r_out_valid;
    logic [SPEED_W-1:0]        r_out_data;

    // Unit handshakes.
    logic               mul_start, mul_done;
    logic [PROD_W-1:0]  mul_prod;
    logic               div_start, div_done;
    logic [DIV_W-1:0]   div_dividend, div_quo;
    logic [DVW-1:0]     div_divisor;
    logic               commit;

    // Combinational helpers.
    logic [PCW-1:0]            per_inc;
    logic signed [DELTA_W-1:0] diff_s, half_s, cpr_s, wrapped;
    logic [DELTA_W-1:0]        mag;
    logic                      big;
    logic [DIV_W-1:0]          lim_num;
    logic signed [NUM_W-1:0]   num_abs;
    logic signed [S19_W-1:0]   speed_x;
    logic signed [DELTA_W-1:0] lim_s, neg_lim_s, speed_s;
    logic [SPEED_W-1:0]        sat_speed, clamp_speed, n_speed;

    // The period counter saturates at all ones.
    assign per_inc = (r_periods == {PCW{1'b1}}) ? r_periods : r_periods + 1'b1;

    // Wrap the raw difference to half a revolution.
    assign diff_s = $signed({r_diff[POS_W-1], r_diff});
    assign half_s = $signed({9'b0, r_cpr[CPR_W-1:1]});
    assign cpr_s  = $signed({8'b0, r_cpr});

    always_comb begin
        if (diff_s > half_s) begin
            wrapped = diff_s - cpr_s;
        end else if (diff_s < -half_s) begin
            wrapped = diff_s + cpr_s;
        end else begin
            wrapped = diff_s;
        end
    end

    // The wrapped magnitude never exceeds 2^31, so 32 bits carry it.
    assign mag = r_delta[DELTA_W-1] ? DELTA_W'(-r_delta) : DELTA_W'(r_delta);
    assign big = (mag[DELTA_W-1:2] != '0);

    // Clamp limit numerator: 5 * rate * 256 = rate * 1024 + rate * 256.
    assign lim_num = (DIV_W'(r_rate) << 10) + (DIV_W'(r_rate) << 8);

    assign num_abs = r_num[NUM_W-1] ? -r_num : r_num;
    assign speed_x = S19_W'(r_speed);

    // Saturate the signed quotient of the average to 32 bits.
    always_comb begin
        if (!r_neg) begin
            sat_speed = (div_quo[DIV_W-1:SPEED_W-1] != '0) ? 32'h7FFF_FFFF
                                                             : div_quo[SPEED_W-1:0];
        end else if ((div_quo[DIV_W-1:SPEED_W] != '0)
                     || (div_quo[SPEED_W-1] && (div_quo[SPEED_W-2:0] != '0))) begin
            sat_speed = 32'h8000_0000;
        end else begin
            sat_speed = -div_quo[SPEED_W-1:0];
        end
    end

    // Clamp against the limit, which stays below 2^27.
    assign lim_s     = $signed({1'b0, div_quo[SPEED_W-1:0]});
    assign neg_lim_s = -lim_s;
    assign speed_s   = DELTA_W'(r_speed);

    always_comb begin
        if (speed_s > lim_s) begin
            clamp_speed = lim_s[SPEED_W-1:0];
        end else if (speed_s < neg_lim_s) begin
            clamp_speed = neg_lim_s[SPEED_W-1:0];
        end else begin
            clamp_speed = r_speed;
        end
    end

    assign n_speed = ((r_kind == K_UPDATE) || (r_kind == K_CLAMP)) ? r_new_speed : r_speed;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        mul_start    = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        commit       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: begin
                n_state = (r_mode || r_awaiting) ? ST_DONE : ST_WRAP;
            end
            ST_WRAP: begin
                n_state = ST_SIGN;
            end
            ST_SIGN: begin
                if (big) begin
                    mul_start = 1'b1;
                    n_state   = ST_MUL;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = lim_num;
                    div_divisor  = DVW'(per_inc);
                    n_state      = ST_LIMIT;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'({mul_prod, {Q_SHIFT{1'b0}}});
                    div_divisor  = DVW'(per_inc);
                    n_state      = ST_TERM;
                end
            end
            ST_TERM: begin
                if (div_done) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_state = ST_AVG;
            end
            ST_AVG: begin
                div_start    = 1'b1;
                div_dividend = num_abs[DIV_W-1:0];
                div_divisor  = DVW'(AVG_DIVISOR);
                n_state      = ST_QUOT;
            end
            ST_QUOT: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_LIMIT: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    commit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Working registers along the way.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_mode <= i_mode;
                    r_pos  <= i_encoder_position;
                end
            end
            ST_DIFF: begin
                r_diff <= r_pos - r_last;
                r_s19  <= (speed_x <<< 4) + (speed_x <<< 1) + speed_x;
                if (r_mode) begin
                    r_kind <= K_COUNT;
                end else if (r_awaiting) begin
                    r_kind <= K_FIRST;
                end
            end
            ST_WRAP: begin
                r_delta <= wrapped;
            end
            ST_SIGN: begin
                r_neg  <= r_delta[DELTA_W-1];
                r_kind <= big ? K_UPDATE : K_CLAMP;
            end
            ST_TERM: begin
                if (div_done) begin
                    r_num <= r_neg ? -NUM_W'(div_quo) : NUM_W'(div_quo);
                end
            end
            ST_SUM: begin
                r_num <= r_num + NUM_W'(r_s19);
            end
            ST_AVG: begin
                r_neg <= r_num[NUM_W-1];
            end
            ST_QUOT: begin
                if (div_done) begin
                    r_new_speed <= sat_speed;
                end
            end
            ST_LIMIT: begin
                if (div_done) begin
                    r_new_speed <= clamp_speed;
                end
            end
            ST_MUL, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Stored state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr      <= CPR_RESET;
            r_rate     <= RATE_RESET;
            r_awaiting <= 1'b1;
            r_last     <= '0;
            r_periods  <= '0;
            r_speed    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_CPR:  r_cpr  <= i_cfg_data[CPR_W-1:0];
                    REG_RATE: r_rate <= i_cfg_data[RATE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (commit) begin
                r_speed <= n_speed;
                unique case (r_kind)
                    K_COUNT: begin
                        r_periods <= per_inc;
                    end
                    K_FIRST: begin
                        r_awaiting <= 1'b0;
                        r_periods  <= '0;
                        r_last     <= r_pos;
                    end
                    K_UPDATE: begin
                        r_periods <= '0;
                        r_last    <= r_pos;
                    end
                    K_CLAMP: begin
                        r_periods <= per_inc;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_data <= n_speed;
        end
    end

    esest_sermul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_mcand (mag[MAG_W-1:0]),
        .i_mplr  (r_rate),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    esest_serdiv #(
        .DVW (DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_speed_estimate = r_out_data;

endmodule

`default_nettype wire

>>> rtl/esest_checker.sv
`default_nettype none

module esest_checker
    import esest_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic [SPEED_W-1:0] o_speed_estimate
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_speed_estimate)))
        else $error("speed item changed or vanished while stalled");

    // Reset leaves the block empty and ready for a sample.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("block not empty after reset");

    // Items are worked one at a time: an accepted sample closes the input.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second sample accepted while one is in work");

    // A new result appears only when the input is open again.
    a_result_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid) && $past(i_rst_n)) |-> o_in_ready)
        else $error("result appeared while a sample is still in work");

endmodule

bind encoder_speed_estimator esest_checker u_esest_checker (.*);

`default_nettype wire
